// ----- sv/spf_pkg.sv -----
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types and constants for the sensor packet framer: opcodes,
// register indexes, header bundle and the beat descriptor of one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spf_pkg;

    localparam int BYTE_W     = 8;
    localparam int MAX_BEATS  = 6;
    localparam int BEAT_IDX_W = $clog2(MAX_BEATS);
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 2;

    // item opcodes
    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_DATA   = 2'd1,
        OP_FINISH = 2'd2,
        OP_RSVD   = 2'd3
    } op_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HDR_A = 2'd0,
        CFG_HDR_B = 2'd1,
        CFG_HDR_C = 2'd2,
        CFG_NONE  = 2'd3
    } cfg_idx_t;

    typedef logic [BYTE_W-1:0] byte_t;

    // configured header bytes
    typedef struct packed {
        byte_t hdr_a;
        byte_t hdr_b;
        byte_t hdr_c;
    } hdr_t;

    // all output beats caused by one item
    typedef struct packed {
        logic [MAX_BEATS-1:0][BYTE_W-1:0] bytes;
        logic [BEAT_IDX_W-1:0]            last_idx;
    } desc_t;

endpackage

// ----- sv/spf_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// spf_cfg_regs
// Header byte registers written over the configuration channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spf_cfg_regs
    import spf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    output hdr_t                 hdr
);

    hdr_t hdr_reg;
    hdr_t hdr_next;

    assign cfg_ready = 1'b1;
    assign hdr       = hdr_reg;

    // register write decode, unknown index ignored
    always_comb
    begin
        hdr_next = hdr_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_HDR_A: hdr_next.hdr_a = cfg_data;
                CFG_HDR_B: hdr_next.hdr_b = cfg_data;
                CFG_HDR_C: hdr_next.hdr_c = cfg_data;
                default:   hdr_next = hdr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg <= '0;
        end
        else
        begin
            hdr_reg <= hdr_next;
        end
    end

endmodule

// ----- sv/spf_frame_state.sv -----
// ----------------------------------------------------------------------------
// spf_frame_state
// Frame counter and running checksum; turns one item into its beat list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spf_frame_state
    import spf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  hdr_t              hdr,
    input  op_t               opcode,
    input  logic [BYTE_W-1:0] payload_length,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              load,
    output logic              has_result,
    output desc_t             desc
);

    logic [CNT_W-1:0]  counter_reg;
    logic [CNT_W-1:0]  counter_next;
    logic [BYTE_W-1:0] xor_reg;
    logic [BYTE_W-1:0] xor_next;
    logic [BYTE_W-1:0] cnt_lo;
    logic [BYTE_W-1:0] cnt_hi;

    assign cnt_lo = counter_reg[BYTE_W-1:0];
    assign cnt_hi = counter_reg[CNT_W-1:BYTE_W];

    // item decode into beats and next frame state
    always_comb
    begin
        desc         = '0;
        has_result   = 1'b0;
        counter_next = counter_reg;
        xor_next     = xor_reg;
        unique case (opcode)
            OP_START:
            begin
                has_result    = 1'b1;
                desc.bytes[0] = hdr.hdr_a;
                desc.bytes[1] = hdr.hdr_b;
                desc.bytes[2] = hdr.hdr_c;
                desc.bytes[3] = cnt_lo;
                desc.bytes[4] = cnt_hi;
                desc.bytes[5] = payload_length;
                desc.last_idx = BEAT_IDX_W'(MAX_BEATS - 1);
                xor_next      = hdr.hdr_a ^ hdr.hdr_b ^ hdr.hdr_c
                                ^ cnt_lo ^ cnt_hi ^ payload_length;
                counter_next  = counter_reg + CNT_W'(1);
            end
            OP_DATA:
            begin
                has_result    = 1'b1;
                desc.bytes[0] = data_byte;
                desc.last_idx = '0;
                xor_next      = xor_reg ^ data_byte;
            end
            OP_FINISH:
            begin
                has_result    = 1'b1;
                desc.bytes[0] = xor_reg;
                desc.bytes[1] = '0;
                desc.last_idx = BEAT_IDX_W'(1);
                xor_next      = '0;
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    // state advances once per item handed on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            xor_reg     <= '0;
        end
        else if (load)
        begin
            counter_reg <= counter_next;
            xor_reg     <= xor_next;
        end
    end

endmodule

// ----- sv/spf_emitter.sv -----
// ----------------------------------------------------------------------------
// spf_emitter
// Result register holding one item's beats; sends them one beat at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spf_emitter
    import spf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  desc_t             desc,
    output logic              free,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] out_byte,
    output logic              run_last
);

    logic                  valid_reg;
    desc_t                 desc_reg;
    logic [BEAT_IDX_W-1:0] idx_reg;
    logic                  at_last;
    logic                  beat_done;

    assign at_last   = (idx_reg == desc_reg.last_idx);
    assign beat_done = valid_reg && !out_stall;
    assign free      = !valid_reg || (beat_done && at_last);

    assign out_valid = valid_reg;
    assign out_byte  = desc_reg.bytes[idx_reg];
    assign run_last  = at_last;

    // beat valid and index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (beat_done)
        begin
            if (at_last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + BEAT_IDX_W'(1);
            end
        end
    end

    // beat bytes
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            desc_reg <= desc;
        end
    end

endmodule

// ----- sv/sensor_packet_framer.sv -----
// ----------------------------------------------------------------------------
// sensor_packet_framer
// An item waits in the input register while the result register sends the
// last item's beats, one byte per beat: one for data, six for a start, two
// for a finish, none for a reserved opcode.
// Reset: asynchronous, clears header registers, frame counter and checksum.
// Builds telemetry frames: header, counter, length, payload, checksum, tail.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_packet_framer
    import spf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           opcode,
    input  logic [BYTE_W-1:0]    payload_length,
    input  logic [BYTE_W-1:0]    data_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [BYTE_W-1:0]    out_byte,
    output logic                 run_last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    logic              item_valid_reg;
    op_t               op_reg;
    logic [BYTE_W-1:0] len_reg;
    logic [BYTE_W-1:0] data_reg;

    hdr_t              hdr;
    desc_t             desc;
    logic              has_result;
    logic              free;
    logic              advance;
    logic              in_accept;

    // item leaves the input register when the result side can take it, or when it makes no beats
    assign advance   = item_valid_reg && (free || !has_result);
    assign in_stall  = item_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg   <= op_t'(opcode);
            len_reg  <= payload_length;
            data_reg <= data_byte;
        end
    end

    spf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .hdr       (hdr)
    );

    spf_frame_state u_state (
        .clk            (clk),
        .rst_n          (rst_n),
        .hdr            (hdr),
        .opcode         (op_reg),
        .payload_length (len_reg),
        .data_byte      (data_reg),
        .load           (advance),
        .has_result     (has_result),
        .desc           (desc)
    );

    spf_emitter u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && has_result),
        .desc      (desc),
        .free      (free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

endmodule

// ----- sim/tb_sensor_packet_framer.sv -----
// ----------------------------------------------------------------------------
// tb_sensor_packet_framer
// Self-checking bench for the telemetry frame builder. A queue-fed driver
// sends start, payload, finish and reserved items with random gaps. A
// monitor applies random backpressure and checks every output beat in order
// against a behavioral frame model. Header registers are rewritten between
// phases, including an unmapped index that must be ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sensor_packet_framer;
    import spf_pkg::*;

    localparam int CYCLE_LIMIT     = 300000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int RANDOM_PHASES   = 4;
    localparam int ITEMS_PER_PHASE = 100;

    typedef struct {
        op_t   op;
        byte_t len;
        byte_t dat;
    } item_t;

    typedef struct {
        byte_t value;
        logic  last;
    } beat_t;

    // dut ports, inputs all known from time zero
    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 in_valid       = 1'b0;
    logic                 in_stall;
    logic [1:0]           opcode         = '0;
    logic [BYTE_W-1:0]    payload_length = '0;
    logic [BYTE_W-1:0]    data_byte      = '0;
    logic                 out_valid;
    logic                 out_stall      = 1'b0;
    logic [BYTE_W-1:0]    out_byte;
    logic                 run_last;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [BYTE_W-1:0]    cfg_data       = '0;

    // pending items and expected frame beats
    item_t item_q[$];
    beat_t frame_beats[$];

    // frame model state
    hdr_t             hdr_mirror = '0;
    logic [CNT_W-1:0] seq_count  = '0;
    byte_t            chk_acc    = '0;

    // bench control and statistics
    logic  hurry        = 1'b0;
    int    send_gap     = 0;
    int    hold_left    = 0;
    item_t send_item;
    int    cycle_count  = 0;
    int    mismatches   = 0;
    int    beats_seen   = 0;
    int    n_start      = 0;
    int    n_data       = 0;
    int    n_finish     = 0;
    int    n_rsvd       = 0;
    int    hdr_settings = 0;

    sensor_packet_framer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .run_last       (run_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // queue one expected beat
    task automatic emit_beat(input byte_t value, input logic last);
        beat_t b;
        b.value = value;
        b.last  = last;
        frame_beats.push_back(b);
    endtask

    // frame model: expected beats of one accepted item
    task automatic frame_model_step(input op_t op, input byte_t len, input byte_t dat);
        case (op)
            OP_START:
            begin
                emit_beat(hdr_mirror.hdr_a, 1'b0);
                emit_beat(hdr_mirror.hdr_b, 1'b0);
                emit_beat(hdr_mirror.hdr_c, 1'b0);
                emit_beat(seq_count[7:0], 1'b0);
                emit_beat(seq_count[15:8], 1'b0);
                emit_beat(len, 1'b1);
                // checksum restarts with the new header
                chk_acc = hdr_mirror.hdr_a ^ hdr_mirror.hdr_b ^ hdr_mirror.hdr_c
                        ^ seq_count[7:0] ^ seq_count[15:8] ^ len;
                seq_count = seq_count + CNT_W'(1);
                n_start++;
            end
            OP_DATA:
            begin
                emit_beat(dat, 1'b1);
                chk_acc = chk_acc ^ dat;
                n_data++;
            end
            OP_FINISH:
            begin
                emit_beat(chk_acc, 1'b0);
                emit_beat(8'h00, 1'b1);
                chk_acc = '0;
                n_finish++;
            end
            default:
            begin
                n_rsvd++;
            end
        endcase
    endtask

    // compare one output beat with the oldest expectation
    task automatic check_beat();
        beat_t exp_b;
        if (frame_beats.size() == 0)
        begin
            $display("%0t: unexpected beat, expected none, actual byte %02h last %0b",
                     $time, out_byte, run_last);
            mismatches++;
        end
        else
        begin
            exp_b = frame_beats.pop_front();
            if (out_byte !== exp_b.value)
            begin
                $display("%0t: out_byte expected %02h actual %02h",
                         $time, exp_b.value, out_byte);
                mismatches++;
            end
            if (run_last !== exp_b.last)
            begin
                $display("%0t: run_last expected %0b actual %0b",
                         $time, exp_b.last, run_last);
                mismatches++;
            end
        end
        beats_seen++;
    endtask

    // input driver: one item per beat, random gap after each accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                frame_model_step(op_t'(opcode), payload_length, data_byte);
                send_gap = hurry ? 0 : $urandom_range(0, 4);
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (item_q.size() > 0)
                begin
                    send_item = item_q.pop_front();
                    in_valid       <= 1'b1;
                    opcode         <= send_item.op;
                    payload_length <= send_item.len;
                    data_byte      <= send_item.dat;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor: check each beat, then stall for a random spell
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_beat();
                hold_left = hurry ? 0 : $urandom_range(0, 4);
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d beats outstanding",
                     $time, cycle_count, frame_beats.size());
            $display("sensor_packet_framer: mismatch");
            $finish;
        end
    end

    // register write over the config channel, mirrored into the model
    task automatic write_reg(input cfg_idx_t idx, input byte_t val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_HDR_A: hdr_mirror.hdr_a = val;
            CFG_HDR_B: hdr_mirror.hdr_b = val;
            CFG_HDR_C: hdr_mirror.hdr_c = val;
            default:   ;
        endcase
    endtask

    // new header setting, plus a write to the unmapped index
    task automatic set_headers(input byte_t a, input byte_t b, input byte_t c);
        write_reg(CFG_HDR_A, a);
        write_reg(CFG_HDR_B, b);
        write_reg(CFG_HDR_C, c);
        write_reg(CFG_NONE, byte_t'($urandom));
        hdr_settings++;
    endtask

    task automatic push_item(input op_t op, input byte_t len, input byte_t dat);
        item_t it;
        it.op  = op;
        it.len = len;
        it.dat = dat;
        item_q.push_back(it);
    endtask

    // drain all traffic, then let the pipeline settle
    task automatic wait_idle();
        do
            @(negedge clk);
        while (item_q.size() != 0 || in_valid || frame_beats.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // one random sequence; returns how many non-reserved items it queued
    task automatic add_random_frame(output int counted);
        int    kind;
        int    n;
        byte_t len;
        kind    = $urandom_range(0, 9);
        counted = 0;
        if (kind < 7 || kind == 9)
        begin
            // start, payload, finish; the declared length may disagree
            n   = $urandom_range(0, 6);
            len = ($urandom_range(0, 3) == 0) ? byte_t'($urandom) : byte_t'(n);
            push_item(OP_START, len, byte_t'($urandom));
            counted++;
            for (int i = 0; i < n; i++)
            begin
                push_item(OP_DATA, byte_t'($urandom), byte_t'($urandom));
                counted++;
            end
            // abandoned frame: the next start restarts the checksum
            if (kind != 9)
            begin
                push_item(OP_FINISH, byte_t'($urandom), byte_t'($urandom));
                counted++;
            end
        end
        else if (kind == 7)
        begin
            // stray payload outside a frame, sometimes closed by a finish
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
            begin
                push_item(OP_DATA, byte_t'($urandom), byte_t'($urandom));
                counted++;
            end
            if ($urandom_range(0, 1) == 1)
            begin
                push_item(OP_FINISH, byte_t'($urandom), byte_t'($urandom));
                counted++;
            end
        end
        else
        begin
            push_item(OP_RSVD, byte_t'($urandom), byte_t'($urandom));
        end
    endtask

    // stimulus
    initial
    begin
        int got;
        int total;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset header values; finish and payload with no frame open
        push_item(OP_FINISH, 8'hFF, 8'hFF);
        push_item(OP_DATA,   8'h00, 8'hFF);
        push_item(OP_DATA,   8'hFF, 8'h00);
        push_item(OP_FINISH, 8'h00, 8'h00);
        push_item(OP_FINISH, 8'h00, 8'h00);
        push_item(OP_RSVD,   8'hFF, 8'hFF);
        push_item(OP_START,  8'h00, 8'hFF);
        // start inside an open frame
        push_item(OP_START,  8'hFF, 8'h00);
        push_item(OP_DATA,   8'h00, 8'hA5);
        push_item(OP_FINISH, 8'hFF, 8'h00);
        wait_idle();

        // all-ones header
        set_headers(8'hFF, 8'hFF, 8'hFF);
        push_item(OP_START,  8'hFF, 8'h00);
        push_item(OP_DATA,   8'h00, 8'h00);
        push_item(OP_DATA,   8'h00, 8'hFF);
        push_item(OP_RSVD,   8'h00, 8'h00);
        push_item(OP_FINISH, 8'h00, 8'h00);
        // empty payload
        push_item(OP_START,  8'h01, 8'h00);
        push_item(OP_FINISH, 8'h00, 8'h00);
        wait_idle();

        // mixed header
        set_headers(8'h00, 8'hFF, 8'h5A);
        push_item(OP_START,  8'h80, 8'h00);
        push_item(OP_DATA,   8'h00, 8'h80);
        push_item(OP_DATA,   8'h00, 8'h7F);
        push_item(OP_FINISH, 8'h00, 8'h00);
        wait_idle();

        // random phases, one of them with no idling on either side
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == RANDOM_PHASES - 1)
                set_headers(8'h00, 8'h00, 8'h00);
            else
                set_headers(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom));
            hurry = (ph == 1);
            total = 0;
            while (total < ITEMS_PER_PHASE)
            begin
                add_random_frame(got);
                total += got;
            end
            wait_idle();
        end
        hurry = 1'b0;

        $display("run covered %0d starts, %0d payload, %0d finish, %0d reserved items",
                 n_start, n_data, n_finish, n_rsvd);
        $display("%0d beats checked over %0d header settings, %0d errors",
                 beats_seen, hdr_settings, mismatches);
        if (mismatches == 0)
            $display("sensor_packet_framer: match");
        else
            $display("sensor_packet_framer: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
sv/spf_pkg.sv
sv/spf_cfg_regs.sv
sv/spf_frame_state.sv
sv/spf_emitter.sv
sv/sensor_packet_framer.sv
sim/tb_sensor_packet_framer.sv
